[src/assert_macros.svh]
// Assertion macros shared by the matrix inverse RTL.
// Every use is clocked by i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A general concurrent property.
`define M4CI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// An implication from a condition to a consequence in the same cycle.
`define M4CI_ASSERT_IMPL(label, ante, cons, msg) \
    `M4CI_ASSERT(label, (ante) |-> (cons), msg)

`endif

[src/m4ci_pkg.sv]
// Shared types, constants and index tables for the 4x4 matrix inverse.
// No dependencies; used by matrix4_cofactor_inverse_core.
`default_nettype none

package m4ci_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] element_value;
        logic                         first_element;
    } t_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic [3:0]                   result_index;
        logic                         singular;
        logic                         saturated;
        logic                         last_result;
    } t_result;

    // Element positions of the 2x2 minors of the top and bottom row pairs:
    // minor = el[j0] * el[j1] - el[j2] * el[j3].
    localparam logic [3:0] MINOR_TAB [12][4] = '{
        '{4'd0, 4'd5, 4'd1, 4'd4},   '{4'd0, 4'd6, 4'd2, 4'd4},
        '{4'd0, 4'd7, 4'd3, 4'd4},   '{4'd1, 4'd6, 4'd2, 4'd5},
        '{4'd1, 4'd7, 4'd3, 4'd5},   '{4'd2, 4'd7, 4'd3, 4'd6},
        '{4'd8, 4'd13, 4'd9, 4'd12}, '{4'd8, 4'd14, 4'd10, 4'd12},
        '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
        '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
    };

    localparam logic [3:0] COF_EL [16][3] = '{
        '{4'd5, 4'd6, 4'd7},    '{4'd1, 4'd2, 4'd3},
        '{4'd13, 4'd14, 4'd15}, '{4'd9, 4'd10, 4'd11},
        '{4'd4, 4'd6, 4'd7},    '{4'd0, 4'd2, 4'd3},
        '{4'd12, 4'd14, 4'd15}, '{4'd8, 4'd10, 4'd11},
        '{4'd4, 4'd5, 4'd7},    '{4'd0, 4'd1, 4'd3},
        '{4'd12, 4'd13, 4'd15}, '{4'd8, 4'd9, 4'd11},
        '{4'd4, 4'd5, 4'd6},    '{4'd0, 4'd1, 4'd2},
        '{4'd12, 4'd13, 4'd14}, '{4'd8, 4'd9, 4'd10}
    };

    localparam logic [3:0] COF_MN [16][3] = '{
        '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd10, 4'd9},
        '{4'd5, 4'd4, 4'd3},   '{4'd5, 4'd4, 4'd3},
        '{4'd11, 4'd8, 4'd7},  '{4'd11, 4'd8, 4'd7},
        '{4'd5, 4'd2, 4'd1},   '{4'd5, 4'd2, 4'd1},
        '{4'd10, 4'd8, 4'd6},  '{4'd10, 4'd8, 4'd6},
        '{4'd4, 4'd2, 4'd0},   '{4'd4, 4'd2, 4'd0},
        '{4'd9, 4'd7, 4'd6},   '{4'd9, 4'd7, 4'd6},
        '{4'd3, 4'd1, 4'd0},   '{4'd3, 4'd1, 4'd0}
    };

    localparam logic [15:0] COF_NEG = 16'b0101_1010_0101_1010;

    function automatic logic [3:0] minor_el(input logic [3:0] k, input logic [1:0] j);
        return MINOR_TAB[k][j];
    endfunction

    function automatic logic [3:0] cof_el(input logic [3:0] k, input logic [1:0] t);
        return COF_EL[k][t];
    endfunction

    function automatic logic [3:0] cof_mn(input logic [3:0] k, input logic [1:0] t);
        return COF_MN[k][t];
    endfunction

    function automatic logic cof_neg(input logic [3:0] k);
        return COF_NEG[k];
    endfunction

endpackage

`default_nettype wire

[src/matrix4_cofactor_inverse_core.sv]
// 4x4 matrix inverse by cofactors in signed fixed point.
// Depends on m4ci_pkg and assert_macros.svh.
//
// Usage: drive i_item with one element (row-major) and raise start; the word
// is taken at a rising edge where start is high and busy is low. Setting
// first_element puts the word at position 0. Loading takes one cycle per
// element. Writing position 15 raises busy and starts the computation.
// The sixteen results leave on o_result, each marked by o_strobe for one
// cycle, in row-major order; the receiver cannot hold them off. busy falls
// in the cycle that carries the sixteenth result.
// Every product runs on one shared shift-add multiplier, which stops once the
// second operand's magnitude is shifted out (24 minor products, 6 determinant
// products, 48 cofactor products), and every quotient runs through a
// one-bit-per-cycle divider of 5*W+2 bits, followed by a rounding and a
// saturation step. A singular matrix is echoed instead, each word read in
// S_ERD and sent in S_EOUT. Reset clears the control state and the load
// position; the element store needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module matrix4_cofactor_inverse_core #(
    parameter int FRAC_BITS = m4ci_pkg::FRAC_BITS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    input  wire m4ci_pkg::t_item    i_item,
    output logic                    busy,
    output logic                    o_strobe,
    output m4ci_pkg::t_result       o_result
);

    localparam int DW = m4ci_pkg::DATA_WIDTH;
    localparam int MW = 2 * DW + 2;     // minor width
    localparam int PW = 2 * MW;         // product width
    localparam int AW = 5 * DW + 2;     // accumulator and divider width
    localparam int CW = $clog2(AW + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RA   = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_MI   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_DCHK = 4'd6;
    localparam logic [3:0] S_DIVI = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_RND  = 4'd9;
    localparam logic [3:0] S_SAT  = 4'd10;
    localparam logic [3:0] S_ERD  = 4'd11;
    localparam logic [3:0] S_EOUT = 4'd12;

    localparam logic [1:0] PH_MINOR = 2'd0;
    localparam logic [1:0] PH_DET   = 2'd1;
    localparam logic [1:0] PH_COF   = 2'd2;

    logic [3:0]    r_state;
    logic [1:0]    r_phase;
    logic [3:0]    r_grp;
    logic [2:0]    r_term;
    logic [3:0]    r_pos;

    logic [DW-1:0] el_mem [16];
    logic [MW-1:0] mn_mem [12];
    logic [DW-1:0] r_el_rd;
    logic [MW-1:0] r_mn_rd;

    logic [MW-1:0] r_opa;
    logic [PW-1:0] r_ma;
    logic [MW-1:0] r_mb;
    logic [PW-1:0] r_prod;
    logic          r_pneg;
    logic [AW-1:0] r_acc;
    logic [AW-1:0] r_det;
    logic [AW-1:0] r_num;
    logic [AW-1:0] r_dmag;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_quot;
    logic          r_qneg;
    logic [CW-1:0] r_cnt;
    logic          r_strobe;
    m4ci_pkg::t_result r_res;

    logic          accept;
    logic          el_we;
    logic [3:0]    wr_pos;
    logic          mn_we;
    logic [3:0]    a_idx;
    logic [3:0]    b_idx;
    logic          a_el;
    logic          b_el;
    logic          t_neg;
    logic          last_term;
    logic [3:0]    el_raddr;
    logic [3:0]    mn_raddr;
    logic [MW-1:0] el_ext;
    logic [MW-1:0] opb;
    logic [MW-1:0] a_mag;
    logic [MW-1:0] b_mag;
    logic [AW-1:0] prod_ext;
    logic [AW-1:0] n_acc;
    logic [AW-1:0] acc_mag;
    logic [AW-1:0] det_mag;
    logic [AW:0]   rem_sh;
    logic [AW:0]   d_ext;
    logic          q_ge;
    logic [AW:0]   n_rem;
    logic [AW-1:0] lim;
    logic          n_sat;
    logic [DW-1:0] n_val;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign el_we    = accept;
    assign wr_pos   = i_item.first_element ? 4'd0 : r_pos;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // Operand addresses and signs of the current product term.
    always_comb begin
        a_idx     = 4'd0;
        b_idx     = 4'd0;
        a_el      = 1'b0;
        b_el      = 1'b0;
        t_neg     = 1'b0;
        last_term = 1'b0;
        case (r_phase)
            PH_MINOR: begin
                a_idx     = m4ci_pkg::minor_el(r_grp, {r_term[0], 1'b0});
                b_idx     = m4ci_pkg::minor_el(r_grp, {r_term[0], 1'b1});
                a_el      = 1'b1;
                b_el      = 1'b1;
                t_neg     = r_term[0];
                last_term = (r_term == 3'd1);
            end
            PH_DET: begin
                a_idx     = {1'b0, r_term};
                b_idx     = 4'd11 - {1'b0, r_term};
                t_neg     = (r_term == 3'd1) || (r_term == 3'd4);
                last_term = (r_term == 3'd5);
            end
            PH_COF: begin
                a_idx     = m4ci_pkg::cof_el(r_grp, r_term[1:0]);
                b_idx     = m4ci_pkg::cof_mn(r_grp, r_term[1:0]);
                a_el      = 1'b1;
                t_neg     = m4ci_pkg::cof_neg(r_grp) ^ r_term[0];
                last_term = (r_term == 3'd2);
            end
            default: begin
                a_idx = 4'd0;
            end
        endcase
    end

    always_comb begin
        if (r_state == S_ERD) begin
            el_raddr = r_grp;
        end else if (r_state == S_RB) begin
            el_raddr = b_idx;
        end else begin
            el_raddr = a_idx;
        end
        mn_raddr = (r_state == S_RB) ? b_idx : a_idx;
    end

    assign mn_we = (r_state == S_ACC) && (r_phase == PH_MINOR) && last_term;

    // Element store and minor store, both with registered read data.
    always_ff @(posedge i_clk) begin
        if (el_we) begin
            el_mem[wr_pos] <= i_item.element_value;
        end
        r_el_rd <= el_mem[el_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mn_we) begin
            mn_mem[r_grp] <= n_acc[MW-1:0];
        end
        r_mn_rd <= mn_mem[mn_raddr];
    end

    always_comb begin
        el_ext   = {{(MW-DW){r_el_rd[DW-1]}}, r_el_rd};
        opb      = b_el ? el_ext : r_mn_rd;
        a_mag    = r_opa[MW-1] ? (~r_opa + MW'(1)) : r_opa;
        b_mag    = opb[MW-1] ? (~opb + MW'(1)) : opb;
        prod_ext = {{(AW-PW){1'b0}}, r_prod};
        n_acc    = r_pneg ? (r_acc - prod_ext) : (r_acc + prod_ext);
        acc_mag  = r_acc[AW-1] ? (~r_acc + AW'(1)) : r_acc;
        det_mag  = r_det[AW-1] ? (~r_det + AW'(1)) : r_det;
        rem_sh   = {r_rem, r_num[AW-1]};
        d_ext    = {1'b0, r_dmag};
        q_ge     = (rem_sh >= d_ext);
        n_rem    = q_ge ? (rem_sh - d_ext) : rem_sh;
        lim      = AW'(1) << (DW - 1);
        if (r_qneg) begin
            n_sat = (r_quot > lim);
            n_val = n_sat ? {1'b1, {(DW-1){1'b0}}} : (~r_quot[DW-1:0] + DW'(1));
        end else begin
            n_sat = (r_quot > (lim - AW'(1)));
            n_val = n_sat ? {1'b0, {(DW-1){1'b1}}} : r_quot[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= 4'd0;
            r_strobe <= 1'b0;
            r_phase  <= PH_MINOR;
            r_grp    <= 4'd0;
            r_term   <= 3'd0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pos <= wr_pos + 4'd1;
                        if (wr_pos == 4'd15) begin
                            r_state <= S_RA;
                            r_phase <= PH_MINOR;
                            r_grp   <= 4'd0;
                            r_term  <= 3'd0;
                            r_acc   <= '0;
                        end
                    end
                end
                S_RA: begin
                    r_state <= S_RB;
                end
                S_RB: begin
                    r_opa   <= a_el ? el_ext : r_mn_rd;
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_ma    <= {{(PW-MW){1'b0}}, a_mag};
                    r_mb    <= b_mag;
                    r_prod  <= '0;
                    r_pneg  <= r_opa[MW-1] ^ opb[MW-1] ^ t_neg;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        r_state <= S_ACC;
                    end else begin
                        if (r_mb[0]) begin
                            r_prod <= r_prod + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (!last_term) begin
                        r_term  <= r_term + 3'd1;
                        r_state <= S_RA;
                    end else begin
                        r_term <= 3'd0;
                        case (r_phase)
                            PH_MINOR: begin
                                r_acc <= '0;
                                if (r_grp == 4'd11) begin
                                    r_phase <= PH_DET;
                                    r_grp   <= 4'd0;
                                end else begin
                                    r_grp <= r_grp + 4'd1;
                                end
                                r_state <= S_RA;
                            end
                            PH_DET: begin
                                r_det   <= n_acc;
                                r_acc   <= '0;
                                r_state <= S_DCHK;
                            end
                            default: begin
                                r_state <= S_DIVI;
                            end
                        endcase
                    end
                end
                S_DCHK: begin
                    r_grp <= 4'd0;
                    if (r_det == '0) begin
                        r_state <= S_ERD;
                    end else begin
                        r_phase <= PH_COF;
                        r_state <= S_RA;
                    end
                end
                S_DIVI: begin
                    r_num   <= acc_mag << (2 * FRAC_BITS);
                    r_dmag  <= det_mag;
                    r_qneg  <= r_acc[AW-1] ^ r_det[AW-1];
                    r_rem   <= '0;
                    r_quot  <= '0;
                    r_cnt   <= CW'(AW);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= n_rem[AW-1:0];
                    r_quot <= {r_quot[AW-2:0], q_ge};
                    r_num  <= r_num << 1;
                    r_cnt  <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    // Round to nearest, ties away from zero, on the magnitude.
                    if ({r_rem, 1'b0} >= d_ext) begin
                        r_quot <= r_quot + AW'(1);
                    end
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res.result_value <= n_val;
                    r_res.result_index <= r_grp;
                    r_res.singular     <= 1'b0;
                    r_res.saturated    <= n_sat;
                    r_res.last_result  <= (r_grp == 4'd15);
                    r_strobe           <= 1'b1;
                    r_acc              <= '0;
                    if (r_grp == 4'd15) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_grp   <= r_grp + 4'd1;
                        r_state <= S_RA;
                    end
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_res.result_value <= r_el_rd;
                    r_res.result_index <= r_grp;
                    r_res.singular     <= 1'b1;
                    r_res.saturated    <= 1'b0;
                    r_res.last_result  <= (r_grp == 4'd15);
                    r_strobe           <= 1'b1;
                    if (r_grp == 4'd15) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_grp   <= r_grp + 4'd1;
                        r_state <= S_ERD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `M4CI_ASSERT(a_strobe_after_busy, o_strobe |-> $past(busy), "result word without a run")
    `M4CI_ASSERT(a_run_starts_at_last, $rose(busy) |-> ($past(wr_pos) == 4'd15), "run started early")
    `M4CI_ASSERT_IMPL(a_sing_not_sat, o_strobe && o_result.singular, !o_result.saturated, "singular word saturated")
    `M4CI_ASSERT_IMPL(a_last_ends_run, o_strobe && o_result.last_result, !busy && (o_result.result_index == 4'd15), "last word did not end the run")
    `M4CI_ASSERT_IMPL(a_div_count, r_state == S_DIV, r_cnt != '0, "divider count ran out")

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for matrix4_cofactor_inverse_core: streams 4x4 matrices
// and compares every inverse word against an exact wide-integer prediction.
// Depends on m4ci_pkg and the core RTL.
`default_nettype none

module testbench;

    typedef logic signed [191:0] t_wide;
    typedef logic signed [m4ci_pkg::DATA_WIDTH-1:0] t_elem;

    localparam t_elem EL_MAX = {1'b0, {(m4ci_pkg::DATA_WIDTH-1){1'b1}}};
    localparam t_elem EL_MIN = {1'b1, {(m4ci_pkg::DATA_WIDTH-1){1'b0}}};
    localparam t_elem ONE_Q  = t_elem'(1) <<< m4ci_pkg::FRAC_BITS_DEF;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    m4ci_pkg::t_item   i_item = '0;
    logic    busy;
    logic    o_strobe;
    m4ci_pkg::t_result o_result;

    matrix4_cofactor_inverse_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    t_elem   matrix_store [16];
    int      load_pos = 0;
    m4ci_pkg::t_result inverse_queue [$];
    int      error_count = 0;
    int      words_sent = 0;
    int      burst_left = 0;

    task automatic report(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic t_wide minor2(input int a, input int b, input int c, input int d);
        t_wide p, q;
        p = t_wide'(matrix_store[a]) * t_wide'(matrix_store[b]);
        q = t_wide'(matrix_store[c]) * t_wide'(matrix_store[d]);
        return p - q;
    endfunction

    // Exact cofactor / determinant, rounded half away from zero, then clipped.
    task automatic divide_round(input t_wide num, input t_wide den,
                                output t_elem val, output logic sat);
        logic neg;
        logic [191:0] n, d, q, r;
        logic [191:0] lim;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = n / d;
        r = n - q * d;
        if ((r << 1) >= d) q = q + 1;
        lim = 192'd1 << (m4ci_pkg::DATA_WIDTH - 1);
        sat = 1'b0;
        if (neg) begin
            if (q > lim) begin
                q = lim;
                sat = 1'b1;
            end
            val = t_elem'(-q);
        end else begin
            if (q > lim - 1) begin
                q = lim - 1;
                sat = 1'b1;
            end
            val = t_elem'(q);
        end
    endtask

    task automatic predict_inverse();
        t_wide mn [12];
        t_wide det, cof, term;
        m4ci_pkg::t_result r;
        for (int k = 0; k < 12; k++)
            mn[k] = minor2(m4ci_pkg::MINOR_TAB[k][0], m4ci_pkg::MINOR_TAB[k][1],
                           m4ci_pkg::MINOR_TAB[k][2], m4ci_pkg::MINOR_TAB[k][3]);
        det = mn[0] * mn[11] - mn[1] * mn[10] + mn[2] * mn[9]
            + mn[3] * mn[8] - mn[4] * mn[7] + mn[5] * mn[6];
        for (int k = 0; k < 16; k++) begin
            r = '0;
            r.result_index = 4'(k);
            r.last_result  = (k == 15);
            if (det == 0) begin
                r.singular = 1'b1;
                r.result_value = matrix_store[k];
            end else begin
                cof = 0;
                for (int t = 0; t < 3; t++) begin
                    term = t_wide'(matrix_store[m4ci_pkg::COF_EL[k][t]])
                         * mn[m4ci_pkg::COF_MN[k][t]];
                    if (m4ci_pkg::COF_NEG[k] ^ t[0]) cof = cof - term;
                    else cof = cof + term;
                end
                divide_round(cof <<< (2 * m4ci_pkg::FRAC_BITS_DEF), det,
                             r.result_value, r.saturated);
            end
            inverse_queue.push_back(r);
        end
    endtask

    // Drives one word at the falling edge and holds it until the core takes it.
    task automatic send_word(input t_elem value, input logic first);
        int pos;
        if (burst_left == 0) begin
            if ($urandom_range(3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge i_clk);
            end
            burst_left = $urandom_range(20, 1);
        end
        burst_left--;
        start <= 1'b1;
        i_item <= '{element_value: value, first_element: first};
        while (busy) @(negedge i_clk);
        // busy only changes at a rising edge, so the word goes in at the next one.
        @(posedge i_clk);
        pos = first ? 0 : load_pos;
        matrix_store[pos] = value;
        load_pos = (pos + 1) % 16;
        words_sent++;
        if (pos == 15) predict_inverse();
        @(negedge i_clk);
    endtask

    task automatic send_matrix(input t_elem m [16]);
        for (int k = 0; k < 16; k++)
            send_word(m[k], (k == 0) && $urandom_range(1));
    endtask

    function automatic t_elem rand_elem(input int mode);
        case (mode)
            0: return t_elem'($urandom);
            1: return t_elem'($urandom_range(8 * 65536)) - t_elem'(4 * 65536);
            default: return t_elem'($urandom_range(15)) - t_elem'(8);
        endcase
    endfunction

    task automatic test_identity_and_scale();
        t_elem m [16];
        foreach (m[k]) m[k] = (k % 5 == 0) ? ONE_Q : '0;
        send_matrix(m);
        // A raw diagonal of one and minus one has an inverse far out of range.
        foreach (m[k]) m[k] = (k % 5 == 0) ? ((k == 5) ? -t_elem'(1) : t_elem'(1)) : '0;
        send_matrix(m);
    endtask

    task automatic test_extremes();
        t_elem m [16];
        foreach (m[k]) m[k] = (k % 5 == 0) ? EL_MAX : ((k % 3 == 0) ? EL_MIN : t_elem'(k));
        send_matrix(m);
    endtask

    task automatic test_singular();
        t_elem m [16];
        foreach (m[k]) m[k] = '0;
        send_matrix(m);
        foreach (m[k]) m[k] = (k < 4 || k >= 12) ? t_elem'(k * 1000 + 7) : t_elem'($urandom);
        for (int k = 12; k < 16; k++) m[k] = m[k - 12];
        send_matrix(m);
    endtask

    task automatic test_restart();
        // An abandoned partial matrix is overwritten after the first-element flag.
        for (int k = 0; k < 7; k++) send_word(t_elem'($urandom), k == 0);
        send_word(t_elem'($urandom), 1'b1);
        for (int k = 1; k < 16; k++) send_word(rand_elem(1), 1'b0);
    endtask

    task automatic test_random();
        t_elem m [16];
        int mode, sel;
        while (words_sent < 170) begin
            sel = $urandom_range(9);
            mode = $urandom_range(2);
            foreach (m[k]) m[k] = rand_elem(mode);
            if (sel == 0) begin
                for (int k = 4; k < 8; k++) m[k] = m[k - 4];
                send_matrix(m);
            end else if (sel == 1) begin
                for (int k = 0; k < $urandom_range(14, 1); k++)
                    send_word(rand_elem(0), k == 0);
                send_word(rand_elem(0), 1'b1);
                load_pos = load_pos;
            end else begin
                send_matrix(m);
            end
        end
        // Complete any partial matrix so every word has a result behind it.
        while (load_pos != 0) send_word(rand_elem(1), 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (inverse_queue.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                m4ci_pkg::t_result e;
                e = inverse_queue.pop_front();
                if (o_result.result_index != e.result_index)
                    report($sformatf("index %0d, expected %0d",
                                     o_result.result_index, e.result_index));
                if (o_result.result_value != e.result_value)
                    report($sformatf("value %h at index %0d, expected %h",
                                     o_result.result_value, e.result_index, e.result_value));
                if (o_result.singular != e.singular)
                    report($sformatf("singular flag wrong at index %0d", e.result_index));
                if (o_result.saturated != e.saturated)
                    report($sformatf("saturated flag wrong at index %0d", e.result_index));
                if (o_result.last_result != e.last_result)
                    report($sformatf("last flag wrong at index %0d", e.result_index));
            end
        end
    end

    initial begin
        #40_000_000;
        $display("matrix4_cofactor_inverse_core test failed");
        $finish;
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_identity_and_scale();
        test_extremes();
        test_singular();
        test_restart();
        test_random();
        start <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) begin
            $display("matrix4_cofactor_inverse_core test passed");
        end else begin
            $display("matrix4_cofactor_inverse_core test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
